### rtl/crd_pkg.sv
// Package for the camera response deframer: sizes, protocol bytes, result
// kinds and the structs passed between the parser, the result queue and the top.
// No dependencies.
`timescale 1ns / 1ps

package crd_pkg;

  // Longest frame the parser follows before it gives up and starts over.
  localparam int MAX_FRAME_LEN = 256;
  localparam int LEN_W         = 17;
  localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);
  localparam int HDR_LEN       = 6;
  localparam int HB_IDX_W      = $clog2(HDR_LEN);

  // Result queue depth; one input beat can push up to two results.
  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int LVL_W         = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CMD_HEADER = 8'hAA;
  localparam logic [7:0] CODE_ACK   = 8'h0E;
  localparam logic [7:0] CODE_NACK  = 8'h0F;
  localparam logic [7:0] CODE_SYNC  = 8'h0D;
  localparam logic [7:0] CODE_SIZE  = 8'h0A;

  typedef enum logic [2:0] {
    KIND_ACK         = 3'd0,
    KIND_NACK        = 3'd1,
    KIND_SYNC        = 3'd2,
    KIND_SIZE        = 3'd3,
    KIND_PAYLOAD     = 3'd4,
    KIND_DATA_GOOD   = 3'd5,
    KIND_WRONG_CHUNK = 3'd6,
    KIND_BAD_SUM     = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        param_one;
    logic [7:0]        param_two;
    logic [7:0]        param_three;
    logic [7:0]        param_four;
    logic [7:0]        chunk_low;
    logic [7:0]        data_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              last;
  } result_t;

  // Results produced by one accepted beat, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } res_pair_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             room;
  } fifo_stat_t;

endpackage

### rtl/crd_ifs.sv
// Stream interfaces of the camera response deframer: received bytes in,
// parsed results out. Depends on crd_pkg.
`timescale 1ns / 1ps

interface crd_in_if import crd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  logic [7:0] expected_chunk;

  modport source (output valid, mode, rx_byte, expected_chunk, input ready);
  modport sink   (input valid, mode, rx_byte, expected_chunk, output ready);
endinterface

interface crd_out_if import crd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [7:0]       param_one;
  logic [7:0]       param_two;
  logic [7:0]       param_three;
  logic [7:0]       param_four;
  logic [7:0]       chunk_low;
  logic [7:0]       data_byte;
  logic [LEN_W-1:0] frame_length;
  logic             last;

  modport source (output valid, kind, param_one, param_two, param_three, param_four,
                  chunk_low, data_byte, frame_length, last, input ready);
  modport sink   (input valid, kind, param_one, param_two, param_three, param_four,
                  chunk_low, data_byte, frame_length, last, output ready);
endinterface

### rtl/crd_parser.sv
// Frame parser: holds the byte count, frame length, checksum and header bytes,
// and turns each accepted beat into zero, one or two results. Depends on crd_pkg.
`timescale 1ns / 1ps

module crd_parser import crd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic      mode,
  input  logic [7:0] rx_byte,
  input  logic [7:0] expected_chunk,
  output res_pair_t res
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] exp_len_r, exp_len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       verify_r, verify_nxt;
  logic [7:0]       hb_r [HDR_LEN];

  logic [CNT_W-1:0] cnt_inc;
  logic [LEN_W-1:0] n_ext;
  logic [LEN_W-1:0] cnt_p2;
  logic [LEN_W-1:0] hdr_len;
  logic             cmd_hit;
  kind_t            cmd_kind;
  logic             clear;

  function automatic kind_t finish_kind(input logic [7:0] chunk, input logic [7:0] want,
                                        input logic [7:0] verify, input logic [7:0] sum);
    kind_t k;
    if (chunk != want) k = KIND_WRONG_CHUNK;
    else if (verify != sum) k = KIND_BAD_SUM;
    else k = KIND_DATA_GOOD;
    return k;
  endfunction

  function automatic result_t make_res(input kind_t k, input logic [7:0] chunk,
                                       input logic [7:0] data, input logic [LEN_W-1:0] len,
                                       input logic last);
    result_t r;
    r = '0;
    r.kind         = k;
    r.chunk_low    = chunk;
    r.data_byte    = data;
    r.frame_length = len;
    r.last         = last;
    return r;
  endfunction

  assign cnt_inc = cnt_r + 1'b1;
  assign n_ext   = LEN_W'(cnt_inc);
  assign cnt_p2  = LEN_W'(cnt_r) + LEN_W'(2);
  assign hdr_len = LEN_W'(HDR_LEN) + LEN_W'({hb_r[3], hb_r[2]});

  always_comb begin
    cmd_hit  = (hb_r[0] == CMD_HEADER);
    cmd_kind = KIND_ACK;
    unique case (hb_r[1])
      CODE_ACK:  cmd_kind = KIND_ACK;
      CODE_NACK: cmd_kind = KIND_NACK;
      CODE_SYNC: cmd_kind = KIND_SYNC;
      CODE_SIZE: cmd_kind = KIND_SIZE;
      default:   cmd_hit  = 1'b0;
    endcase
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    exp_len_nxt = exp_len_r;
    sum_nxt     = sum_r;
    verify_nxt  = verify_r;
    clear       = 1'b0;
    res         = '0;
    if (accept) begin
      if (mode) begin
        clear = 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
        if (cnt_inc < CNT_W'(HDR_LEN)) begin
          // Chunk id and size bytes feed the checksum.
          if (cnt_r < CNT_W'(4)) begin
            sum_nxt = ((cnt_r == '0) ? 8'd0 : sum_r) + rx_byte;
          end
        end else if (cnt_inc == CNT_W'(HDR_LEN)) begin
          if (cmd_hit) begin
            res.count            = 2'd1;
            res.res0             = '0;
            res.res0.kind        = cmd_kind;
            res.res0.param_one   = hb_r[2];
            res.res0.param_two   = hb_r[3];
            res.res0.param_three = hb_r[4];
            res.res0.param_four  = rx_byte;
            res.res0.frame_length = LEN_W'(HDR_LEN);
            res.res0.last        = 1'b1;
            clear                = 1'b1;
          end else begin
            exp_len_nxt = hdr_len;
            if (hdr_len == LEN_W'(HDR_LEN)) begin
              // Empty packet: byte 4 is the verify byte and the frame ends here.
              verify_nxt = hb_r[4];
              res.count  = 2'd1;
              res.res0   = make_res(finish_kind(hb_r[0], expected_chunk, hb_r[4], sum_r),
                                    hb_r[0], 8'd0, hdr_len, 1'b1);
              clear      = 1'b1;
            end else if (hdr_len == LEN_W'(HDR_LEN + 1)) begin
              verify_nxt = rx_byte;
              sum_nxt    = sum_r + hb_r[4];
              res.count  = 2'd1;
              res.res0   = make_res(KIND_PAYLOAD, hb_r[0], hb_r[4], hdr_len, 1'b1);
            end else begin
              // Bytes 4 and 5 are both payload and leave together.
              sum_nxt   = sum_r + hb_r[4] + rx_byte;
              res.count = 2'd2;
              res.res0  = make_res(KIND_PAYLOAD, hb_r[0], hb_r[4], hdr_len, 1'b0);
              res.res1  = make_res(KIND_PAYLOAD, hb_r[0], rx_byte, hdr_len, 1'b1);
            end
          end
        end else if (n_ext >= exp_len_r) begin
          res.count = 2'd1;
          res.res0  = make_res(finish_kind(hb_r[0], expected_chunk, verify_r, sum_r),
                               hb_r[0], 8'd0, exp_len_r, 1'b1);
          clear     = 1'b1;
        end else if (cnt_inc >= CNT_W'(MAX_FRAME_LEN)) begin
          clear = 1'b1;
        end else if (cnt_p2 < exp_len_r) begin
          sum_nxt   = sum_r + rx_byte;
          res.count = 2'd1;
          res.res0  = make_res(KIND_PAYLOAD, hb_r[0], rx_byte, exp_len_r, 1'b1);
        end else if (cnt_p2 == exp_len_r) begin
          verify_nxt = rx_byte;
        end else begin
          // High verify byte: counted only.
          verify_nxt = verify_r;
        end
      end
      if (clear) begin
        cnt_nxt     = '0;
        exp_len_nxt = LEN_W'(HDR_LEN);
        sum_nxt     = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      exp_len_r <= LEN_W'(HDR_LEN);
      sum_r     <= 8'd0;
      verify_r  <= 8'd0;
    end else begin
      cnt_r     <= cnt_nxt;
      exp_len_r <= exp_len_nxt;
      sum_r     <= sum_nxt;
      verify_r  <= verify_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !mode && (cnt_r < CNT_W'(HDR_LEN))) begin
      hb_r[cnt_r[HB_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

### rtl/crd_out_fifo.sv
// Result queue: takes up to two results per cycle from the parser and hands
// them out one per cycle while pop is high. Depends on crd_pkg.
`timescale 1ns / 1ps

module crd_out_fifo import crd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_pair_t  push,
  input  logic       pop,
  output result_t    head,
  output fifo_stat_t stat
);

  result_t          mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign level_nxt  = level_r + LVL_W'(push.count) - LVL_W'(pop);

  assign head       = mem_r[rd_ptr_r];
  assign stat.level = level_r;
  assign stat.room  = (level_r <= LVL_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

endmodule

### rtl/camera_response_deframer.sv
// Top level of the camera response deframer: parser plus result queue.
// Depends on crd_pkg, crd_ifs, crd_parser and crd_out_fifo.
//
//   channel  direction  handshake          beat carries
//   in_ch    sink       valid / ready      mode, rx_byte, expected_chunk
//   out_ch   source     valid / ready      kind, four params, chunk_low,
//                                          data_byte, frame_length, last
//
// A beat on in_ch is parsed in the cycle it is accepted; its results are
// queued and leave on out_ch one per cycle while out_ch.ready is high. Input
// runs at one beat per cycle until the queue fills; the limit is the single
// read port of the four-entry result queue, since one beat can yield two
// results. in_ch.ready is high while the queue has two free entries, so
// input keeps flowing while earlier results wait for out_ch.ready.
// Reset is synchronous and active low and returns the parser to the start of
// a frame with an empty queue; stored header bytes are not cleared.
`timescale 1ns / 1ps

module camera_response_deframer import crd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  crd_in_if.sink   in_ch,
  crd_out_if.source out_ch
);

  logic       accept;
  logic       pop;
  res_pair_t  pair;
  result_t    head;
  fifo_stat_t stat;

  // Accepting only with room for two results keeps the queue from overrunning
  // regardless of what the beat turns out to produce.
  assign in_ch.ready = stat.room;
  assign accept      = in_ch.valid && in_ch.ready;

  crd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .mode           (in_ch.mode),
    .rx_byte        (in_ch.rx_byte),
    .expected_chunk (in_ch.expected_chunk),
    .res            (pair)
  );

  crd_out_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (pair),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  assign out_ch.valid        = (stat.level != '0);
  assign pop                 = out_ch.valid && out_ch.ready;
  assign out_ch.kind         = head.kind;
  assign out_ch.param_one    = head.param_one;
  assign out_ch.param_two    = head.param_two;
  assign out_ch.param_three  = head.param_three;
  assign out_ch.param_four   = head.param_four;
  assign out_ch.chunk_low    = head.chunk_low;
  assign out_ch.data_byte    = head.data_byte;
  assign out_ch.frame_length = head.frame_length;
  assign out_ch.last         = head.last;

  // A restart beat never produces a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.mode) |-> (pair.count == 2'd0))
    else $error("restart beat produced a result");

  // When a beat yields two results only the second one closes it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pair.count == 2'd2) |-> (!pair.res0.last && pair.res1.last))
    else $error("last flag misplaced on a two-result beat");

  // Results are only pushed when the queue had room for two.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pair.count != 2'd0) |-> stat.room)
    else $error("result pushed without queue room");

  // The queue level never exceeds its depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    stat.level <= LVL_W'(FIFO_DEPTH))
    else $error("result queue overflow");

endmodule
